FILE: rtl/sqb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_pkg
// shared types, codes and constants of the sprite quad batcher
// ----------------------------------------------------------------------------
package sqb_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BATCH_A,
        ST_PREP,
        ST_CORDIC,
        ST_CS,
        ST_PROD,
        ST_ROT,
        ST_VERT,
        ST_BATCH_B
    } t_state;

    typedef enum logic [1:0] {
        CFG_CAMERA_X    = 2'd0,
        CFG_CAMERA_Y    = 2'd1,
        CFG_CAMERA_ZOOM = 2'd2
    } t_cfg_idx;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_BATCH  = 1'b1;

    localparam logic [15:0]        TEX_NONE   = 16'hFFFF;
    localparam logic signed [33:0] CORDIC_X0  = 34'sd652032875;
    localparam logic signed [16:0] Q15_ONE    = 17'sd32768;
    localparam logic [39:0]        HALF_SAT   = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] tex;
        logic [14:0] start;
        logic [14:0] count;
    } t_batch;

    typedef struct packed {
        logic               has_a;
        t_batch             batch_a;
        logic               has_s;
        logic               has_b;
        t_batch             batch_b;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        src_w;
        logic [15:0]        src_h;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic [15:0]        rot;
        logic [15:0]        u0;
        logic [15:0]        v0;
        logic [15:0]        u1;
        logic [15:0]        v1;
        logic [31:0]        color;
        logic [15:0]        vbase;
    } t_entry;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        zoom;
    } t_cam;

    // arctangent steps in binary angle units
    function automatic logic [13:0] atan_lut(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/sprite_quad_batcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_batcher_top
// sorted, textured sprites in; quad vertices and draw batch records out
// ----------------------------------------------------------------------------
// input channel: one sprite per transfer (i_valid / o_ready); the front end
//   decides batch records, capacity and vertex numbers at once and queues
//   the sprite, so o_ready only drops while the two-entry queue is full
// output channel: one record per transfer (o_valid / i_ready); a sprite gives
//   an optional closing batch record, four vertices TL, TR, BR, BL when it
//   is valid and fits, and on the frame's last sprite the final batch
//   record when it is not empty; o_last marks the final record of each sprite
// sequence: the back end pops a sprite, sets up, runs the 16-step cordic,
//   forms cosine and sine, then the products, and for each vertex rotates
//   and loads the output register; a closing batch record is loaded before
//   the first vertex and the final one after the last; the back end pops
//   the next sprite only once it is back in idle
// configuration: i_cfg_we writes camera x, y and zoom by index; writes are
//   to be made only while the block is idle, which the block does not enforce
// reset: synchronous, active low; open batch closed, counters cleared,
//   zoom back to one, queue and output register empty
// receiver stall: the output register holds its record and the back end
//   waits to load; the front keeps taking sprites until the queue fills
// ----------------------------------------------------------------------------
module sprite_quad_batcher_top #(
    parameter int MAX_QUADS       = 4096,
    parameter int TEXTURE_ID_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // sprite channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_texture_id,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [15:0]        i_src_width,
    input  logic [15:0]        i_src_height,
    input  logic [15:0]        i_scale_x,
    input  logic [15:0]        i_scale_y,
    input  logic [15:0]        i_rotation,
    input  logic [63:0]        i_uv_rect,
    input  logic [1:0]         i_flip,
    input  logic [31:0]        i_color,
    input  logic               i_last_sprite,
    // record channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic signed [31:0] o_vert_x,
    output logic signed [31:0] o_vert_y,
    output logic [15:0]        o_vert_u,
    output logic [15:0]        o_vert_v,
    output logic [31:0]        o_vert_color,
    output logic [15:0]        o_vertex_index,
    output logic [15:0]        o_batch_texture,
    output logic [14:0]        o_batch_start,
    output logic [14:0]        o_batch_count,
    output logic               o_last
);
    import sqb_pkg::*;

    // index capacity, six per quad, kept inside 15 bits
    localparam int CAP     = (MAX_QUADS * 6 > 32766) ? 32766 : MAX_QUADS * 6;
    // all-ones id of the texture width marks an invalid sprite
    localparam int TEX_INV = (TEXTURE_ID_BITS >= 16) ? 65535
                                                     : (1 << TEXTURE_ID_BITS) - 1;

    t_cam   r_cam;
    t_entry fr_entry, q_entry;
    logic   accept, fr_push, q_full, q_empty, q_pop;

    // camera registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam.x    <= '0;
            r_cam.y    <= '0;
            r_cam.zoom <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAMERA_X:    r_cam.x    <= $signed(i_cfg_data);
                CFG_CAMERA_Y:    r_cam.y    <= $signed(i_cfg_data);
                CFG_CAMERA_ZOOM: r_cam.zoom <= i_cfg_data;
                default:         r_cam      <= r_cam;
            endcase
        end
    end

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    sqb_front #(
        .CAP     (CAP),
        .TEX_INV (TEX_INV)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_texture_id  (i_texture_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_src_width   (i_src_width),
        .i_src_height  (i_src_height),
        .i_scale_x     (i_scale_x),
        .i_scale_y     (i_scale_y),
        .i_rotation    (i_rotation),
        .i_uv_rect     (i_uv_rect),
        .i_flip        (i_flip),
        .i_color       (i_color),
        .i_last_sprite (i_last_sprite),
        .o_push        (fr_push),
        .o_entry       (fr_entry)
    );

    sqb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_entry),
        .o_empty (q_empty)
    );

    sqb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cam           (r_cam),
        .i_empty         (q_empty),
        .i_entry         (q_entry),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_vert_x        (o_vert_x),
        .o_vert_y        (o_vert_y),
        .o_vert_u        (o_vert_u),
        .o_vert_v        (o_vert_v),
        .o_vert_color    (o_vert_color),
        .o_vertex_index  (o_vertex_index),
        .o_batch_texture (o_batch_texture),
        .o_batch_start   (o_batch_start),
        .o_batch_count   (o_batch_count),
        .o_last          (o_last)
    );

`ifndef NO_ASSERTIONS
    a_no_empty_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_BATCH) |-> (o_batch_count != 15'd0))
        else $error("empty batch record emitted");

    a_vertex_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_VERTEX) |->
            (o_batch_texture == 16'd0 && o_batch_start == 15'd0 && o_batch_count == 15'd0))
        else $error("vertex record carries batch fields");

    // a stalled record stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_kind) && $stable(o_vert_x) && $stable(o_vert_y)
             && $stable(o_vertex_index) && $stable(o_batch_count) && $stable(o_last)))
        else $error("stalled record changed");
`endif

endmodule

FILE: rtl/sqb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_queue
// two-entry queue of classified sprites between front and back
// ----------------------------------------------------------------------------
module sqb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sqb_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output sqb_pkg::t_entry o_data,
    output logic            o_empty
);
    import sqb_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("queue written while full");
`endif

endmodule

FILE: rtl/sqb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_front
// batch bookkeeping: decides batch records, capacity and vertex numbers
// ----------------------------------------------------------------------------
module sqb_front #(
    parameter int CAP     = 24576,
    parameter int TEX_INV = 65535
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [15:0]     i_texture_id,
    input  logic [31:0]     i_pos_x,
    input  logic [31:0]     i_pos_y,
    input  logic [15:0]     i_src_width,
    input  logic [15:0]     i_src_height,
    input  logic [15:0]     i_scale_x,
    input  logic [15:0]     i_scale_y,
    input  logic [15:0]     i_rotation,
    input  logic [63:0]     i_uv_rect,
    input  logic [1:0]      i_flip,
    input  logic [31:0]     i_color,
    input  logic            i_last_sprite,
    output logic            o_push,
    output sqb_pkg::t_entry o_entry
);
    import sqb_pkg::*;

    localparam logic [15:0] CAP_W = 16'(CAP);
    localparam logic [15:0] INV_W = 16'(TEX_INV);

    logic [15:0] r_open_tex,  n_open_tex;
    logic [14:0] r_open_start, n_open_start;
    logic [14:0] r_index_total, n_index_total;
    logic [15:0] r_vertex_total, n_vertex_total;

    logic        open_valid, tex_ok, tex_change, fits, mid_valid;
    logic [15:0] mid_tex;
    logic [14:0] mid_start, mid_idx;
    logic [15:0] mid_vtot;

    always_comb begin
        open_valid = (r_open_tex != TEX_NONE) && (r_open_tex != INV_W);
        tex_ok     = (i_texture_id != INV_W);
        tex_change = tex_ok && (i_texture_id != r_open_tex);
        mid_tex    = tex_change ? i_texture_id : r_open_tex;
        mid_start  = tex_change ? r_index_total : r_open_start;
        fits       = ({1'b0, r_index_total} + 16'd6) <= CAP_W;

        o_entry.has_a         = tex_change && open_valid && (r_index_total > r_open_start);
        o_entry.batch_a.tex   = r_open_tex;
        o_entry.batch_a.start = r_open_start;
        o_entry.batch_a.count = r_index_total - r_open_start;
        o_entry.has_s         = tex_ok && fits;

        mid_idx  = o_entry.has_s ? (r_index_total + 15'd6) : r_index_total;
        mid_vtot = o_entry.has_s ? (r_vertex_total + 16'd4) : r_vertex_total;
        mid_valid = (mid_tex != TEX_NONE) && (mid_tex != INV_W);

        o_entry.has_b         = i_last_sprite && mid_valid && (mid_idx > mid_start);
        o_entry.batch_b.tex   = mid_tex;
        o_entry.batch_b.start = mid_start;
        o_entry.batch_b.count = mid_idx - mid_start;

        o_entry.pos_x   = $signed(i_pos_x);
        o_entry.pos_y   = $signed(i_pos_y);
        o_entry.src_w   = i_src_width;
        o_entry.src_h   = i_src_height;
        o_entry.scale_x = i_scale_x;
        o_entry.scale_y = i_scale_y;
        o_entry.rot     = i_rotation;
        // flips swap the two texture edges
        o_entry.u0      = i_flip[0] ? i_uv_rect[47:32] : i_uv_rect[15:0];
        o_entry.u1      = i_flip[0] ? i_uv_rect[15:0]  : i_uv_rect[47:32];
        o_entry.v0      = i_flip[1] ? i_uv_rect[63:48] : i_uv_rect[31:16];
        o_entry.v1      = i_flip[1] ? i_uv_rect[31:16] : i_uv_rect[63:48];
        o_entry.color   = i_color;
        o_entry.vbase   = r_vertex_total;

        if (i_last_sprite) begin
            n_open_tex     = TEX_NONE;
            n_open_start   = 15'd0;
            n_index_total  = 15'd0;
            n_vertex_total = 16'd0;
        end else begin
            n_open_tex     = mid_tex;
            n_open_start   = mid_start;
            n_index_total  = mid_idx;
            n_vertex_total = mid_vtot;
        end
    end

    assign o_push = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_tex     <= TEX_NONE;
            r_open_start   <= 15'd0;
            r_index_total  <= 15'd0;
            r_vertex_total <= 16'd0;
        end else if (i_accept) begin
            r_open_tex     <= n_open_tex;
            r_open_start   <= n_open_start;
            r_index_total  <= n_index_total;
            r_vertex_total <= n_vertex_total;
        end
    end

`ifndef NO_ASSERTIONS
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_index_total} <= CAP_W && r_open_start <= r_index_total)
        else $error("index total beyond capacity");
`endif

endmodule

FILE: rtl/sqb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_back
// quad geometry: cordic, zoom, rotation and output record sequencing
// ----------------------------------------------------------------------------
module sqb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sqb_pkg::t_cam      i_cam,
    input  logic               i_empty,
    input  sqb_pkg::t_entry    i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic signed [31:0] o_vert_x,
    output logic signed [31:0] o_vert_y,
    output logic [15:0]        o_vert_u,
    output logic [15:0]        o_vert_v,
    output logic [31:0]        o_vert_color,
    output logic [15:0]        o_vertex_index,
    output logic [15:0]        o_batch_texture,
    output logic [14:0]        o_batch_start,
    output logic [14:0]        o_batch_count,
    output logic               o_last
);
    import sqb_pkg::*;

    function automatic logic signed [16:0] clamp_q15(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [18:0] q;
        logic signed [16:0] r;
        t = v + 34'sd16384;
        q = t[33:15];
        if (q > 19'sd32768)       r = 17'sd32768;
        else if (q < -19'sd32768) r = -17'sd32768;
        else                      r = q[16:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v[50:31] == {20{1'b0}} || v[50:31] == {20{1'b1}}) r = v[31:0];
        else if (v[50])                                        r = 32'sh8000_0000;
        else                                                   r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    t_state r_state, n_state;
    t_entry r_ent;

    logic [31:0]        r_pw, r_ph;
    logic signed [32:0] r_dx, r_dy;
    logic signed [40:0] r_hw, r_hh;
    logic signed [49:0] r_scx, r_scy;
    logic signed [33:0] r_cx, r_cy;
    logic signed [17:0] r_z;
    logic               r_neg;
    logic [3:0]         r_iter;
    logic signed [16:0] r_cos, r_sin;
    logic signed [57:0] r_p1, r_p2, r_p3, r_p4;
    logic [1:0]         r_k;
    logic signed [44:0] r_rx, r_ry;
    logic               r_out_valid;

    logic can_load, load_a, load_b, load_v, is_last_vert;
    logic sx_neg, sy_neg;

    // combinational helpers
    logic signed [17:0] a_ext, z_init;
    logic               neg_init;
    logic signed [33:0] dx_c, dy_c;
    logic signed [17:0] atan_s;
    logic [63:0]        pw_z, ph_z;
    logic [54:0]        pw_sh, ph_sh;
    logic signed [65:0] dx_z, dy_z;
    logic signed [59:0] e1, e2, e3, e4, sum_x, sum_y;
    logic signed [50:0] vx, vy;

    assign can_load     = !r_out_valid || i_ready;
    assign is_last_vert = (r_k == 2'd3);
    assign sx_neg       = (r_k == 2'd0) || (r_k == 2'd3);
    assign sy_neg       = (r_k == 2'd0) || (r_k == 2'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_entry.has_a)      n_state = ST_BATCH_A;
                    else if (i_entry.has_s) n_state = ST_PREP;
                    else if (i_entry.has_b) n_state = ST_BATCH_B;
                    else                    n_state = ST_IDLE;
                end
            end
            ST_BATCH_A: begin
                if (can_load) begin
                    if (r_ent.has_s)      n_state = ST_PREP;
                    else if (r_ent.has_b) n_state = ST_BATCH_B;
                    else                  n_state = ST_IDLE;
                end
            end
            ST_PREP:   n_state = ST_CORDIC;
            ST_CORDIC: if (r_iter == 4'd15) n_state = ST_CS;
            ST_CS:     n_state = ST_PROD;
            ST_PROD:   n_state = ST_ROT;
            ST_ROT:    n_state = ST_VERT;
            ST_VERT: begin
                if (can_load) begin
                    if (!is_last_vert)    n_state = ST_ROT;
                    else if (r_ent.has_b) n_state = ST_BATCH_B;
                    else                  n_state = ST_IDLE;
                end
            end
            ST_BATCH_B: if (can_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        load_a = 1'b0;
        load_b = 1'b0;
        load_v = 1'b0;
        unique case (r_state)
            ST_IDLE:    o_pop  = !i_empty;
            ST_BATCH_A: load_a = can_load;
            ST_VERT:    load_v = can_load;
            ST_BATCH_B: load_b = can_load;
            default: begin
                o_pop  = 1'b0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        a_ext = {{2{i_entry.rot[15]}}, i_entry.rot};
        if (a_ext > 18'sd16384) begin
            z_init   = a_ext - 18'sd32768;
            neg_init = 1'b1;
        end else if (a_ext < -18'sd16384) begin
            z_init   = a_ext + 18'sd32768;
            neg_init = 1'b1;
        end else begin
            z_init   = a_ext;
            neg_init = 1'b0;
        end

        dx_c   = r_cy >>> r_iter;
        dy_c   = r_cx >>> r_iter;
        atan_s = $signed({4'd0, atan_lut(r_iter)});

        pw_z  = r_pw * i_cam.zoom;
        ph_z  = r_ph * i_cam.zoom;
        pw_sh = pw_z[63:9];
        ph_sh = ph_z[63:9];
        dx_z  = r_dx * $signed({1'b0, i_cam.zoom});
        dy_z  = r_dy * $signed({1'b0, i_cam.zoom});

        e1 = {{2{r_p1[57]}}, r_p1};
        e2 = {{2{r_p2[57]}}, r_p2};
        e3 = {{2{r_p3[57]}}, r_p3};
        e4 = {{2{r_p4[57]}}, r_p4};
        sum_x = (sx_neg ? -e1 : e1) - (sy_neg ? -e2 : e2) + 60'sd16384;
        sum_y = (sx_neg ? -e3 : e3) + (sy_neg ? -e4 : e4) + 60'sd16384;

        vx = {r_scx[49], r_scx} + {{6{r_rx[44]}}, r_rx};
        vy = {r_scy[49], r_scy} + {{6{r_ry[44]}}, r_ry};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;

        unique case (r_state)
            ST_IDLE: begin
                r_cx   <= CORDIC_X0;
                r_cy   <= '0;
                r_z    <= z_init;
                r_neg  <= neg_init;
                r_iter <= 4'd0;
            end
            ST_PREP: begin
                r_pw <= r_ent.src_w * r_ent.scale_x;
                r_ph <= r_ent.src_h * r_ent.scale_y;
                r_dx <= {r_ent.pos_x[31], r_ent.pos_x} - {i_cam.x[31], i_cam.x};
                r_dy <= {r_ent.pos_y[31], r_ent.pos_y} - {i_cam.y[31], i_cam.y};
            end
            ST_CORDIC: begin
                if (!r_z[17]) begin
                    r_cx <= r_cx - dx_c;
                    r_cy <= r_cy + dy_c;
                    r_z  <= r_z - atan_s;
                end else begin
                    r_cx <= r_cx + dx_c;
                    r_cy <= r_cy - dy_c;
                    r_z  <= r_z + atan_s;
                end
                r_iter <= r_iter + 4'd1;
                // half extents and screen centre settle while the cordic runs
                r_hw  <= (pw_sh[54:40] != '0) ? $signed({1'b0, HALF_SAT})
                                              : $signed({1'b0, pw_sh[39:0]});
                r_hh  <= (ph_sh[54:40] != '0) ? $signed({1'b0, HALF_SAT})
                                              : $signed({1'b0, ph_sh[39:0]});
                r_scx <= dx_z[65:16];
                r_scy <= dy_z[65:16];
            end
            ST_CS: begin
                if (r_ent.rot == 16'd0) begin
                    r_cos <= Q15_ONE;
                    r_sin <= '0;
                end else if (r_neg) begin
                    r_cos <= -clamp_q15(r_cx);
                    r_sin <= -clamp_q15(r_cy);
                end else begin
                    r_cos <= clamp_q15(r_cx);
                    r_sin <= clamp_q15(r_cy);
                end
            end
            ST_PROD: begin
                r_p1 <= r_hw * r_cos;
                r_p2 <= r_hh * r_sin;
                r_p3 <= r_hw * r_sin;
                r_p4 <= r_hh * r_cos;
                r_k  <= 2'd0;
            end
            ST_ROT: begin
                r_rx <= sum_x[59:15];
                r_ry <= sum_y[59:15];
            end
            ST_VERT: begin
                if (can_load) r_k <= r_k + 2'd1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase

        // output register payload
        if (load_a || load_b) begin
            o_kind          <= KIND_BATCH;
            o_vert_x        <= '0;
            o_vert_y        <= '0;
            o_vert_u        <= '0;
            o_vert_v        <= '0;
            o_vert_color    <= '0;
            o_vertex_index  <= '0;
            o_batch_texture <= load_a ? r_ent.batch_a.tex   : r_ent.batch_b.tex;
            o_batch_start   <= load_a ? r_ent.batch_a.start : r_ent.batch_b.start;
            o_batch_count   <= load_a ? r_ent.batch_a.count : r_ent.batch_b.count;
            o_last          <= load_b || !(r_ent.has_s || r_ent.has_b);
        end else if (load_v) begin
            o_kind          <= KIND_VERTEX;
            o_vert_x        <= sat32(vx);
            o_vert_y        <= sat32(vy);
            o_vert_u        <= sx_neg ? r_ent.u0 : r_ent.u1;
            o_vert_v        <= sy_neg ? r_ent.v0 : r_ent.v1;
            o_vert_color    <= r_ent.color;
            o_vertex_index  <= r_ent.vbase + {14'd0, r_k};
            o_batch_texture <= '0;
            o_batch_start   <= '0;
            o_batch_count   <= '0;
            o_last          <= is_last_vert && !r_ent.has_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_a || load_b || load_v) r_out_valid <= 1'b1;
            else if (i_ready)               r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule
